@@ rtl/core/lqwm_pkg.sv @@
// Shared types and constants for the link quality window monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lqwm_pkg;

	localparam int unsigned GRACE_W   = 16;
	localparam int unsigned MINS_W    = 5;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned RUN_W     = 16;
	localparam int unsigned TOTAL_W   = 32;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FRESH_GRACE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERCENT = 2'd2;

	localparam logic [GRACE_W-1:0] GRACE_RST       = 16'd5000;
	localparam logic [MINS_W-1:0]  MIN_SAMPLES_RST = 5'd5;
	localparam logic [PCT_W-1:0]   MIN_PERCENT_RST = 7'd80;
	localparam logic [PCT_W-1:0]   PCT_SCALE       = 7'd100;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

@@ rtl/core/lqwm_divider.sv @@
// Restoring divider, one quotient bit per cycle, started by the sequencer.
// Depends on lqwm_pkg for the status struct.
`timescale 1ns / 1ps

module lqwm_divider #(
	parameter int unsigned DVD_W = 12,
	parameter int unsigned DVS_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVS_W-1:0]     divisor,
	output logic [DVD_W-1:0]     quotient,
	output lqwm_pkg::div_status_t status
);
	import lqwm_pkg::*;

	localparam int unsigned CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = (cnt_q != '0);
	assign status.done = done_q;

endmodule

@@ rtl/core/lqwm_window.sv @@
// Outcome window, fill and success counts, saturating totals and last good time.
// Depends on lqwm_pkg for field widths.
`timescale 1ns / 1ps

module lqwm_window #(
	parameter int unsigned WINDOW = 20,
	parameter int unsigned CNT_W  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          ok,
	input  logic [lqwm_pkg::TIME_W-1:0]   now,
	input  logic [lqwm_pkg::GRACE_W-1:0]  grace,
	output logic [CNT_W-1:0]              fill,
	output logic [CNT_W-1:0]              ones,
	output logic                          fresh,
	output logic [lqwm_pkg::RUN_W-1:0]    failure_run,
	output logic [lqwm_pkg::TOTAL_W-1:0]  good_total,
	output logic [lqwm_pkg::TOTAL_W-1:0]  bad_total
);
	import lqwm_pkg::*;

	logic [WINDOW-1:0]  win_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   ones_q;
	logic [RUN_W-1:0]   run_q;
	logic [TOTAL_W-1:0] good_q;
	logic [TOTAL_W-1:0] bad_q;
	logic [TIME_W-1:0]  last_good_q;
	logic               have_good_q;
	logic [TIME_W-1:0]  age;

	assign age   = now - last_good_q;
	assign fresh = have_good_q && (age <= TIME_W'(grace));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			fill_q      <= '0;
			ones_q      <= '0;
			run_q       <= '0;
			good_q      <= '0;
			bad_q       <= '0;
			have_good_q <= 1'b0;
		end else if (upd) begin
			win_q  <= {win_q[WINDOW-2:0], ok};
			ones_q <= ones_q + CNT_W'(ok) - CNT_W'(win_q[WINDOW-1]);
			if (fill_q < CNT_W'(WINDOW)) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (ok) begin
				run_q       <= '0;
				have_good_q <= 1'b1;
				if (good_q != '1) begin
					good_q <= good_q + TOTAL_W'(1);
				end
			end else begin
				if (run_q != '1) begin
					run_q <= run_q + RUN_W'(1);
				end
				if (bad_q != '1) begin
					bad_q <= bad_q + TOTAL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd && ok) begin
			last_good_q <= now;
		end
	end

	assign fill        = fill_q;
	assign ones        = ones_q;
	assign failure_run = run_q;
	assign good_total  = good_q;
	assign bad_total   = bad_q;

endmodule

@@ rtl/core/link_quality_window_monitor_unit.sv @@
// Link quality window monitor: top level with sequencer, config and output register.
// Depends on lqwm_pkg, lqwm_window and lqwm_divider.
// The sequencer steps through start, run and, while the output register is stalled, hold states;
// the divider's dividend width is DVD_W = clog2(WINDOW + 1) + 7 for the percentage divide.
// in_stall stays high from an accepted item until its result is loaded, so items do not overlap.
// Reset clears the window, counters and handshake state and restores register defaults.
`timescale 1ns / 1ps

module link_quality_window_monitor_unit #(
	parameter int unsigned WINDOW = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lqwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lqwm_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             success,
	input  logic [lqwm_pkg::TIME_W-1:0]      time_ms,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lqwm_pkg::MINS_W-1:0]      sample_count,
	output logic [lqwm_pkg::PCT_W-1:0]       success_percent,
	output logic                             degraded,
	output logic                             online,
	output logic [lqwm_pkg::RUN_W-1:0]       fail_streak,
	output logic [lqwm_pkg::TOTAL_W-1:0]     success_total,
	output logic [lqwm_pkg::TOTAL_W-1:0]     error_total
);
	import lqwm_pkg::*;

	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned DVD_W = CNT_W + PCT_W;
	localparam int unsigned CMP_W = (CNT_W > MINS_W) ? CNT_W : MINS_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]         state_q;
	logic [GRACE_W-1:0] grace_q;
	logic [MINS_W-1:0]  min_samples_q;
	logic [PCT_W-1:0]   min_pct_q;
	logic               ok_q;
	logic               fresh_q;
	logic               out_valid_q;

	logic               accept;
	logic               slot_free;
	logic               load;
	logic               div_start;
	logic [CNT_W-1:0]   fill;
	logic [CNT_W-1:0]   ones;
	logic               fresh;
	logic [RUN_W-1:0]   run;
	logic [TOTAL_W-1:0] good_total;
	logic [TOTAL_W-1:0] bad_total;
	logic [DVD_W-1:0]   quotient;
	div_status_t        div_st;
	logic               deg;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign div_start = (state_q == ST_START);
	assign load      = ((state_q == ST_RUN && div_st.done) || state_q == ST_HOLD) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q       <= GRACE_RST;
			min_samples_q <= MIN_SAMPLES_RST;
			min_pct_q     <= MIN_PERCENT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRESH_GRACE: grace_q       <= cfg_data;
				CFG_MIN_SAMPLES: min_samples_q <= cfg_data[MINS_W-1:0];
				CFG_MIN_PERCENT: min_pct_q     <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	lqwm_window #(
		.WINDOW (WINDOW),
		.CNT_W  (CNT_W)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (accept),
		.ok          (success),
		.now         (time_ms),
		.grace       (grace_q),
		.fill        (fill),
		.ones        (ones),
		.fresh       (fresh),
		.failure_run (run),
		.good_total  (good_total),
		.bad_total   (bad_total)
	);

	lqwm_divider #(
		.DVD_W (DVD_W),
		.DVS_W (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DVD_W'(ones) * DVD_W'(PCT_SCALE)),
		.divisor  (fill),
		.quotient (quotient),
		.status   (div_st)
	);

	assign deg = (CMP_W'(fill) >= CMP_W'(min_samples_q)) && (quotient < DVD_W'(min_pct_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_START;
				ST_START: state_q <= ST_RUN;
				ST_RUN: begin
					if (div_st.done) begin
						state_q <= slot_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD:  if (slot_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= success;
			fresh_q <= fresh;
		end
		if (load) begin
			sample_count    <= MINS_W'(fill);
			success_percent <= quotient[PCT_W-1:0];
			degraded        <= deg;
			online          <= !deg && (ok_q || fresh_q);
			fail_streak     <= run;
			success_total   <= good_total;
			error_total     <= bad_total;
		end
	end

	assign out_valid = out_valid_q;

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> success_percent <= PCT_SCALE)
		else $error("success percent above full scale");

	a_online_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(online && degraded))
		else $error("online while degraded");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> fill != '0)
		else $error("divide with empty window");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_RUN)
		else $error("divider finished outside run state");

	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> state_q == ST_RUN)
		else $error("divider busy outside run state");

	a_rose_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_RUN || state_q == ST_HOLD))
		else $error("result appeared without a divide");

endmodule

@@ tb/lqwm_status_check.sv @@
// Checker for the link quality window monitor: watches both channels and the register port.
// Predicts each result from its own copy of the window, counters and registers.
// Depends on lqwm_pkg; reports failures and outstanding results to the testbench top.
`timescale 1ns / 1ps

module lqwm_status_check #(
	parameter int unsigned WINDOW = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lqwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lqwm_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             success,
	input  logic [lqwm_pkg::TIME_W-1:0]      time_ms,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [lqwm_pkg::MINS_W-1:0]      sample_count,
	input  logic [lqwm_pkg::PCT_W-1:0]       success_percent,
	input  logic                             degraded,
	input  logic                             online,
	input  logic [lqwm_pkg::RUN_W-1:0]       fail_streak,
	input  logic [lqwm_pkg::TOTAL_W-1:0]     success_total,
	input  logic [lqwm_pkg::TOTAL_W-1:0]     error_total,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);
	import lqwm_pkg::*;

	typedef struct packed {
		logic [MINS_W-1:0]  fill;
		logic [PCT_W-1:0]   pct;
		logic               deg;
		logic               onl;
		logic [RUN_W-1:0]   run;
		logic [TOTAL_W-1:0] good;
		logic [TOTAL_W-1:0] bad;
	} link_status_t;

	link_status_t       status_due_q[$];
	link_status_t       want;
	link_status_t       got;
	logic [WINDOW-1:0]  outcome_hist;
	int unsigned        fill;
	int unsigned        pct;
	logic [RUN_W-1:0]   fail_run;
	logic [TOTAL_W-1:0] good_total;
	logic [TOTAL_W-1:0] bad_total;
	logic [TIME_W-1:0]  last_good_ms;
	logic [TIME_W-1:0]  age_ms;
	logic               have_good;
	logic               deg_now;
	logic [GRACE_W-1:0] grace_ms;
	logic [MINS_W-1:0]  min_fill;
	logic [PCT_W-1:0]   min_pct;
	int unsigned        mismatches;

	task automatic check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_due_q.delete();
			outcome_hist = '0;
			fill = 0;
			fail_run = '0;
			good_total = '0;
			bad_total = '0;
			last_good_ms = '0;
			have_good = 1'b0;
			grace_ms = GRACE_RST;
			min_fill = MIN_SAMPLES_RST;
			min_pct = MIN_PERCENT_RST;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRESH_GRACE: grace_ms = cfg_data[GRACE_W-1:0];
					CFG_MIN_SAMPLES: min_fill = cfg_data[MINS_W-1:0];
					CFG_MIN_PERCENT: min_pct = cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{sample_count, success_percent, degraded, online,
					fail_streak, success_total, error_total};
				if (status_due_q.size() == 0) begin
					$display("%0t: result with no item outstanding, expected none, got %p",
						$time, got);
					mismatches++;
				end else begin
					want = status_due_q.pop_front();
					check_field("sample_count", want.fill, got.fill);
					check_field("success_percent", want.pct, got.pct);
					check_field("degraded", want.deg, got.deg);
					check_field("online", want.onl, got.onl);
					check_field("fail_streak", want.run, got.run);
					check_field("success_total", want.good, got.good);
					check_field("error_total", want.bad, got.bad);
				end
			end
			if (in_valid && !in_stall) begin
				outcome_hist = {outcome_hist[WINDOW-2:0], success};
				if (fill < WINDOW)
					fill++;
				pct = ($countones(outcome_hist) * 100) / fill;
				deg_now = (fill >= min_fill) && (pct < min_pct);
				age_ms = time_ms - last_good_ms;
				if (success) begin
					if (good_total != '1)
						good_total++;
					fail_run = '0;
					last_good_ms = time_ms;
					have_good = 1'b1;
					want.onl = !deg_now;
				end else begin
					if (bad_total != '1)
						bad_total++;
					if (fail_run != '1)
						fail_run++;
					want.onl = have_good && (age_ms <= grace_ms) && !deg_now;
				end
				want.fill = fill[MINS_W-1:0];
				want.pct = pct[PCT_W-1:0];
				want.deg = deg_now;
				want.run = fail_run;
				want.good = good_total;
				want.bad = bad_total;
				status_due_q.push_back(want);
			end
		end
		fail_count <= mismatches;
		pending <= status_due_q.size();
	end

endmodule

@@ tb/tb.sv @@
// Testbench top for link_quality_window_monitor_unit: clock, reset, stimulus and verdict.
// Depends on lqwm_pkg, the block and lqwm_status_check, which predicts and compares.
`timescale 1ns / 1ps

module tb;
	import lqwm_pkg::*;

	localparam int unsigned WINDOW      = 20;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 success;
	logic [TIME_W-1:0]    time_ms;
	logic                 out_valid;
	logic                 out_stall;
	logic [MINS_W-1:0]    sample_count;
	logic [PCT_W-1:0]     success_percent;
	logic                 degraded;
	logic                 online;
	logic [RUN_W-1:0]     fail_streak;
	logic [TOTAL_W-1:0]   success_total;
	logic [TOTAL_W-1:0]   error_total;

	int unsigned          fail_count;
	int unsigned          pending;
	int unsigned          cycles = 0;
	logic                 idle_on;
	int unsigned          stall_left;
	int unsigned          grace_now;
	logic [TIME_W-1:0]    t_now;
	logic [TIME_W-1:0]    last_ok_t;
	logic                 seen_ok;
	int unsigned          ok_bias;
	int unsigned          pick;
	logic                 poll_ok;
	logic [TIME_W-1:0]    poll_ms;

	always #5 clk = ~clk;

	link_quality_window_monitor_unit #(.WINDOW(WINDOW)) DUT (.*);

	lqwm_status_check #(.WINDOW(WINDOW)) status_check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("link_quality_window_monitor_unit test failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_poll(input logic ok, input logic [TIME_W-1:0] t);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		success <= ok;
		time_ms <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (ok) begin
			last_ok_t = t;
			seen_ok = 1'b1;
		end
		t_now = t;
	endtask

	// drain, then write all three registers, with random bits above the min samples and min percent fields
	task automatic set_regs(input int unsigned grace, input int unsigned mins,
		input int unsigned pct);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRESH_GRACE;
		cfg_data <= 16'(grace);
		@(posedge clk);
		cfg_index <= CFG_MIN_SAMPLES;
		cfg_data <= {11'($urandom), 5'(mins)};
		@(posedge clk);
		cfg_index <= CFG_MIN_PERCENT;
		cfg_data <= {9'($urandom), 7'(pct)};
		@(posedge clk);
		cfg_we <= 1'b0;
		grace_now = grace;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FRESH_GRACE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		success <= 1'b0;
		time_ms <= '0;
		idle_on <= 1'b0;
		grace_now = GRACE_RST;
		t_now = '0;
		last_ok_t = '0;
		seen_ok = 1'b0;
		ok_bias = 50;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: no good sample yet, good sample at zero, grace edge, wrap, time going back
		send_poll(1'b0, 32'd0);
		send_poll(1'b1, 32'd0);
		send_poll(1'b0, 32'd5000);
		send_poll(1'b0, 32'd5001);
		send_poll(1'b1, 32'hFFFF_FFF0);
		send_poll(1'b0, 32'h0000_0010);
		send_poll(1'b1, 32'd1000);
		send_poll(1'b0, 32'd999);
		send_poll(1'b1, 32'hFFFF_FFFF);
		send_poll(1'b0, 32'h5555_AAAA);
		send_poll(1'b1, 32'hAAAA_5555);

		// zero grace, zero min fill, threshold above 100
		set_regs(0, 0, 127);
		send_poll(1'b1, 32'd100);
		send_poll(1'b0, 32'd100);
		send_poll(1'b0, 32'd101);

		// widest grace, min fill above the window, zero threshold
		set_regs(65535, 31, 0);
		send_poll(1'b0, 32'd65635);
		send_poll(1'b0, 32'd65636);

		// fill the window completely
		set_regs(5000, 20, 100);
		repeat (6) send_poll(1'b1, t_now + 10);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_regs(5000, 5, 80);
				1: set_regs(0, 1, 100);
				2: set_regs(65535, 20, 0);
				3: set_regs($urandom_range(0, 65535), 21, 101);
				4: set_regs($urandom_range(0, 2000), 0, 127);
				5: set_regs($urandom_range(0, 65535), $urandom_range(1, 20),
					$urandom_range(0, 100));
				6: set_regs(300, $urandom_range(0, 31), $urandom_range(0, 127));
				default: set_regs($urandom_range(100, 8000), $urandom_range(1, 20),
					$urandom_range(50, 100));
			endcase
			idle_on <= (phase != 7) && (phase % 3 != 2);
			for (int n = 0; n < 85; n++) begin
				if (n % 20 == 0)
					ok_bias = $urandom_range(5, 100);
				poll_ok = $urandom_range(1, 100) <= ok_bias;
				pick = $urandom_range(0, 99);
				if (seen_ok && pick < 12)
					poll_ms = last_ok_t + grace_now + $urandom_range(0, 1);
				else if (seen_ok && pick < 18)
					poll_ms = last_ok_t - $urandom_range(1, 5000);
				else if (pick < 24)
					poll_ms = $urandom;
				else
					poll_ms = t_now + $urandom_range(0, grace_now / 3 + 50);
				send_poll(poll_ok, poll_ms);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("link_quality_window_monitor_unit test passed");
		else
			$display("link_quality_window_monitor_unit test failed");
		$finish;
	end

endmodule
